[sv/nkrx_pkg.sv]
// ----------------------------------------------------------------------------
// nkrx_pkg
// shared types and constants of the nonce keyed rolling xor stream
// ----------------------------------------------------------------------------
package nkrx_pkg;

	localparam int NONCE_BYTES_DEF = 16;
	localparam int HASH_W          = 64;
	localparam int HASH_SHIFT      = 5;
	localparam int KEY_BYTES       = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [HASH_W-1:0] HASH_START = 64'd5381;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// command handed from front to back
	typedef struct packed {
		logic              emit;
		logic              xor_en;
		logic              load_key;
		logic [HASH_W-1:0] key;
		logic [7:0]        data;
		logic              last;
	} cmd_t;

endpackage

[sv/nkrx_front.sv]
// ----------------------------------------------------------------------------
// nkrx_front
// accepts message bytes, folds the nonce into the hash and classifies bytes
// ----------------------------------------------------------------------------
module nkrx_front #(
	parameter int NONCE_BYTES = nkrx_pkg::NONCE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               encode_mode,
	input  logic               in_valid,
	output logic               in_ready,
	input  nkrx_pkg::in_item_t in_data,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output nkrx_pkg::cmd_t     cmd_data
);
	import nkrx_pkg::*;

	localparam int CNT_W = $clog2(NONCE_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(NONCE_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NONCE_BYTES - 1);

	logic [CNT_W-1:0]  nonce_cnt_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_next;
	logic              in_nonce;
	logic              nonce_end;
	logic              accept;

	assign in_nonce  = (nonce_cnt_q != CNT_DONE);
	assign nonce_end = in_nonce && (nonce_cnt_q == CNT_LAST);
	assign hash_next = (hash_q << HASH_SHIFT) + hash_q + HASH_W'(in_data.data_byte);
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;

	// nonce bytes only reach the back when echoed or when they close the nonce
	assign cmd_valid = in_valid && (!in_nonce || encode_mode || nonce_end);

	always_comb begin
		cmd_data          = '0;
		cmd_data.emit     = !in_nonce || encode_mode;
		cmd_data.xor_en   = !in_nonce;
		cmd_data.load_key = nonce_end;
		cmd_data.key      = hash_next;
		cmd_data.data     = in_data.data_byte;
		cmd_data.last     = in_data.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_cnt_q <= '0;
			hash_q      <= HASH_START;
		end else if (accept) begin
			if (in_data.last_byte) begin
				nonce_cnt_q <= '0;
				hash_q      <= HASH_START;
			end else if (in_nonce) begin
				nonce_cnt_q <= nonce_cnt_q + 1'b1;
				hash_q      <= hash_next;
			end
		end
	end

endmodule

[sv/nkrx_queue.sv]
// ----------------------------------------------------------------------------
// nkrx_queue
// short fifo of commands between front and back
// ----------------------------------------------------------------------------
module nkrx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  nkrx_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output nkrx_pkg::cmd_t pop_data
);
	import nkrx_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/nkrx_back.sv]
// ----------------------------------------------------------------------------
// nkrx_back
// key store, xor and output register
// ----------------------------------------------------------------------------
module nkrx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  nkrx_pkg::cmd_t      cmd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nkrx_pkg::out_item_t out_data
);
	import nkrx_pkg::*;

	// key kept rotated: slot k holds key byte at (position + k) mod 8
	logic [7:0] key_q [KEY_BYTES];
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       pop;

	assign cmd_ready = !out_valid_q || out_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd_data.load_key) begin
				for (int k = 0; k < KEY_BYTES; k++) begin
					key_q[k] <= cmd_data.key[8*k +: 8];
				end
			end else if (cmd_data.xor_en) begin
				// slot 2 takes slot 0, then advance one position
				for (int k = 0; k < KEY_BYTES; k++) begin
					if (k == 1) begin
						key_q[k] <= key_q[0];
					end else begin
						key_q[k] <= key_q[(k + 1) % KEY_BYTES];
					end
				end
			end
			if (cmd_data.emit) begin
				out_data_q.out_byte <= cmd_data.xor_en ? (cmd_data.data ^ key_q[1])
				                                       : cmd_data.data;
				out_data_q.out_last <= cmd_data.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && cmd_data.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[sv/nonce_keyed_rolling_xor_stream.sv]
// ----------------------------------------------------------------------------
// nonce_keyed_rolling_xor_stream
// byte stream cipher keyed by a djb2 hash of a leading nonce
// ----------------------------------------------------------------------------
// usage
//   in channel  : one message byte per request, the first NONCE_BYTES bytes
//                 are the nonce, last_byte closes the message
//   out channel : echoed nonce bytes (encode mode) and xor-ed payload bytes,
//                 out_last copies last_byte of the causing byte
//   cfg channel : one bit, encode_mode; always ready, write while idle
// timing
//   one byte per cycle sustained unless the output stalls; a byte that yields
//   output passes the queue entry, then the output register; a nonce byte in
//   decode mode yields nothing and updates the hash, the final one also loads
//   the key; the rate is set by the back stage: one key byte read and one key
//   slot move per cycle, the front does one 64-bit shift-add per nonce byte
// reset
//   arst_n clears the nonce count, the hash (to 5381), the queue and the
//   output valid; encode_mode returns to 0; the key store needs no reset
// stall
//   when out_ready is low the output register holds, the two-entry queue
//   fills and then in_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module nonce_keyed_rolling_xor_stream #(
	parameter int NONCE_BYTES = nkrx_pkg::NONCE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  nkrx_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nkrx_pkg::out_item_t out_data
);
	import nkrx_pkg::*;

	// configuration register
	logic encode_mode_q;

	// front to queue
	logic fq_valid;
	logic fq_ready;
	cmd_t fq_data;

	// queue to back
	logic qb_valid;
	logic qb_ready;
	cmd_t qb_data;

	// the register takes every write at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			encode_mode_q <= cfg_data;
		end
	end

	// front: nonce count, hash fold, classification of each byte
	nkrx_front #(
		.NONCE_BYTES(NONCE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.encode_mode(encode_mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cmd_valid  (fq_valid),
		.cmd_ready  (fq_ready),
		.cmd_data   (fq_data)
	);

	// decoupling queue, lets the front keep taking bytes while the back stalls
	nkrx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_data)
	);

	// back: key load, rolling key update, xor and output register
	nkrx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd_data (qb_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

[sim/nonce_keyed_rolling_xor_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_keyed_rolling_xor_stream_tb
// self-checking bench for the nonce keyed rolling xor stream
// ----------------------------------------------------------------------------
// messages are queued as byte requests and driven through the valid/ready
// input; each accepted request runs through a local model of the djb2 nonce
// hash and the rotating key ring, which queues the expected output bytes.
// the output monitor compares every accepted result with the oldest entry.
// encode_mode is rewritten only while the block has drained, including once
// in the middle of a nonce. random gaps on both sides, one gap-free phase,
// long output stalls to back the block up, and drain pauses between phases.
// ----------------------------------------------------------------------------
module nonce_keyed_rolling_xor_stream_tb;

	import nkrx_pkg::*;

	localparam int NONCE_LEN   = NONCE_BYTES_DEF;
	localparam int IDLE_PCT    = 37;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AT_A   = 60;
	localparam int HOLD_AT_B   = 200;
	localparam int RAND_ITEMS  = 360;
	localparam int PHASES      = 6;
	localparam int SETTLE      = 6;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// byte requests waiting to be driven, and predicted output bytes
	in_item_t  msg_byte_q[$];
	out_item_t cipher_out_q[$];

	// local copy of the block state
	bit          encode_on = 1'b0;
	int          nonce_seen = 0;
	logic [63:0] djb_hash = HASH_START;
	logic [7:0]  key_ring [KEY_BYTES];
	logic [2:0]  ring_pos = 3'd0;

	bit          gaps_on = 1'b1;
	int          mismatch_cnt = 0;
	int          results_got = 0;
	int          hold_cnt = 0;

	always #5 clk = ~clk;

	nonce_keyed_rolling_xor_stream uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// advance the model by one accepted byte and queue what it must produce
	function automatic void roll_cipher_step(in_item_t req);
		logic [2:0] pos;
		out_item_t  res;
		int         j;
		if (nonce_seen < NONCE_LEN) begin
			// nonce byte: fold into hash, load key ring on the final one
			djb_hash = (djb_hash << HASH_SHIFT) + djb_hash + 64'(req.data_byte);
			nonce_seen++;
			if (nonce_seen == NONCE_LEN)
				for (j = 0; j < KEY_BYTES; j++)
					key_ring[j] = djb_hash[8*j +: 8];
			// decode mode swallows the nonce
			if (encode_on) begin
				res.out_byte = req.data_byte;
				res.out_last = req.last_byte;
				cipher_out_q.push_back(res);
			end
		end else begin
			// payload byte: xor with the next key slot, then rotate one slot along
			pos = ring_pos;
			res.out_byte = req.data_byte ^ key_ring[pos + 3'd1];
			res.out_last = req.last_byte;
			cipher_out_q.push_back(res);
			key_ring[pos + 3'd2] = key_ring[pos];
			ring_pos = pos + 3'd1;
		end
		// end of message returns to the nonce phase, key ring is kept
		if (req.last_byte) begin
			nonce_seen = 0;
			djb_hash = HASH_START;
			ring_pos = 3'd0;
		end
	endfunction

	// input driver: predict on acceptance, then offer the next pending request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				roll_cipher_step(in_data);
			// payload may only change once the current request is taken
			if (!in_valid || in_ready) begin
				if (msg_byte_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_data <= msg_byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: check each accepted result, drive random or long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_out_q.size() == 0) begin
					$error("unexpected output byte %02h last %0b", out_data.out_byte,
						out_data.out_last);
					mismatch_cnt++;
				end else begin
					if (out_data.out_byte !== cipher_out_q[0].out_byte) begin
						$error("out_byte expected %02h got %02h", cipher_out_q[0].out_byte,
							out_data.out_byte);
						mismatch_cnt++;
					end
					if (out_data.out_last !== cipher_out_q[0].out_last) begin
						$error("out_last expected %0b got %0b", cipher_out_q[0].out_last,
							out_data.out_last);
						mismatch_cnt++;
					end
					void'(cipher_out_q.pop_front());
				end
				results_got++;
				// back the block up so its queue fills and in_ready drops
				if (results_got == HOLD_AT_A || results_got == HOLD_AT_B)
					hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	task automatic push_byte(logic [7:0] val, logic last);
		in_item_t req;
		req.data_byte = val;
		req.last_byte = last;
		msg_byte_q.push_back(req);
	endtask

	task automatic push_message(int unsigned len);
		int unsigned k;
		for (k = 1; k <= len; k++)
			push_byte(8'($urandom), k == len);
	endtask

	// hold off new requests until everything has come out, then let any
	// silent nonce byte finish inside the block
	task automatic wait_drained();
		do
			@(posedge clk);
		while (msg_byte_q.size() != 0 || in_valid || cipher_out_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		encode_on = mode;
	endtask

	initial begin
		int ph;
		int k;
		int phase_items;
		int r;
		int unsigned len;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decode after reset: message ends inside the nonce, nothing comes out
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b1);
		wait_drained();

		// encode: one-byte message, echo carries the last flag
		write_mode(1'b1);
		push_byte(8'hff, 1'b1);
		wait_drained();

		// encode part of a nonce, switch to decode mid-message, finish the
		// nonce silently, then two payload bytes at the extremes
		for (k = 0; k < NONCE_LEN - 6; k++)
			push_byte(k[0] ? 8'hff : 8'h00, 1'b0);
		wait_drained();
		write_mode(1'b0);
		for (k = 0; k < 6; k++)
			push_byte(k[0] ? 8'h80 : 8'h01, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b1);
		wait_drained();

		// decode: last flag on the final nonce byte, no output
		for (k = 0; k < NONCE_LEN; k++)
			push_byte(8'($urandom), k == NONCE_LEN - 1);
		wait_drained();

		// random phases, mode alternates; phase 2 runs with no gaps at all
		for (ph = 0; ph < PHASES; ph++) begin
			gaps_on = (ph != 2);
			write_mode(ph % 2 == 0);
			phase_items = 0;
			while (phase_items < RAND_ITEMS / PHASES) begin
				r = $urandom_range(0, 99);
				if (r < 12)
					len = $urandom_range(1, NONCE_LEN - 1);
				else if (r < 20)
					len = NONCE_LEN;
				else
					len = NONCE_LEN + $urandom_range(1, 24);
				push_message(len);
				phase_items += len;
				// let the driver work down the backlog
				while (msg_byte_q.size() > 8)
					@(posedge clk);
			end
			wait_drained();
		end

		gaps_on = 1'b1;
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && cipher_out_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			if (cipher_out_q.size() != 0)
				$error("%0d expected output bytes never arrived", cipher_out_q.size());
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[nonce_keyed_rolling_xor_stream.f]
sv/nkrx_pkg.sv
sv/nkrx_front.sv
sv/nkrx_queue.sv
sv/nkrx_back.sv
sv/nonce_keyed_rolling_xor_stream.sv
sim/nonce_keyed_rolling_xor_stream_tb.sv
